>>> src/bcc_pkg.sv
package bcc_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int STAMP_BITS_DEF = 32;
  localparam int MASK_BITS = 4;
  localparam int CNT_BITS = 8;
  localparam int THR_BITS = 16;
  localparam int IDX_OUT_BITS = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CLICK = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_CLICK = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MULTI_CLICK = 3'd4;

  localparam logic [MASK_BITS-1:0] ENABLE_RST = 4'hF;
  localparam logic [MASK_BITS-1:0] ACTIVE_RST = 4'h0;
  localparam logic [THR_BITS-1:0] MIN_CLICK_RST = 16'd50;
  localparam logic [THR_BITS-1:0] LONG_CLICK_RST = 16'd1000;
  localparam logic [THR_BITS-1:0] MULTI_CLICK_RST = 16'd300;

  localparam logic KIND_CLICK = 1'b0;
  localparam logic KIND_LONG = 1'b1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [CNT_BITS-1:0] count;
  } bcc_event_t;

endpackage

>>> src/bcc_ram.sv
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/bcc_update.sv
module bcc_update #(
  parameter int STAMP_BITS = bcc_pkg::STAMP_BITS_DEF
) (
  input  logic                                        enable,
  input  logic                                        active_level,
  input  logic                                        pin,
  input  logic [STAMP_BITS-1:0]                       now,
  input  logic [bcc_pkg::THR_BITS-1:0]                min_ms,
  input  logic [bcc_pkg::THR_BITS-1:0]                long_ms,
  input  logic [bcc_pkg::THR_BITS-1:0]                multi_ms,
  input  logic [2*STAMP_BITS+bcc_pkg::CNT_BITS+1:0]   st_in,
  output logic [2*STAMP_BITS+bcc_pkg::CNT_BITS+1:0]   st_out,
  output bcc_pkg::bcc_event_t                         ev
);

  import bcc_pkg::*;

  logic                  pressed, n_pressed;
  logic [STAMP_BITS-1:0] pstamp, n_pstamp;
  logic [STAMP_BITS-1:0] rstamp, n_rstamp;
  logic                  pend, n_pend;
  logic [CNT_BITS-1:0]   cnt, n_cnt;
  logic                  down;
  logic [STAMP_BITS-1:0] held;
  logic [STAMP_BITS-1:0] idle;

  always_comb begin
    {pressed, pstamp, rstamp, pend, cnt} = st_in;
    n_pressed = pressed;
    n_pstamp  = pstamp;
    n_rstamp  = rstamp;
    n_pend    = pend;
    n_cnt     = cnt;
    ev        = '0;
    down      = (pin == active_level);
    held      = now - pstamp;
    if (enable) begin
      if (down != pressed) begin
        n_pressed = down;
        if (down) begin
          n_pstamp = now;
        end else if (held >= STAMP_BITS'(min_ms)) begin
          if (held >= STAMP_BITS'(long_ms)) begin
            ev.valid = 1'b1;
            ev.kind  = KIND_LONG;
            ev.count = cnt;
            n_cnt    = '0;
            n_pend   = 1'b0;
          end else begin
            if (cnt != CNT_MAX) begin
              n_cnt = cnt + 1'b1;
            end
            n_rstamp = now;
            n_pend   = 1'b1;
          end
        end
      end
    end
    idle = now - n_rstamp;
    if (enable && n_pend && !n_pressed && (idle > STAMP_BITS'(multi_ms))) begin
      ev.valid = 1'b1;
      ev.kind  = KIND_CLICK;
      ev.count = n_cnt;
      n_cnt    = '0;
      n_pend   = 1'b0;
    end
    st_out = {n_pressed, n_pstamp, n_rstamp, n_pend, n_cnt};
  end

endmodule

>>> src/button_click_classifier.sv
// processing: the walk visits each button position in turn (state memory
// read-modify-write), then releases the final event of the item; in_stall
// stays high until then, so a new item is taken only after the last one is done;
// an event waiting on a stalled output holds the walk for as long as the stall lasts
// reset: synchronous active-low; registers take defaults, button state released, ms counter zero
module button_click_classifier #(
  parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF,
  parameter int STAMP_BITS = bcc_pkg::STAMP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bcc_pkg::MASK_BITS-1:0]        in_pin_levels,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bcc_pkg::IDX_OUT_BITS-1:0]     out_button_index,
  output logic                                 out_event_kind,
  output logic [bcc_pkg::CNT_BITS-1:0]         out_click_count,
  output logic                                 out_last_event,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bcc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import bcc_pkg::*;

  localparam int NB = (NUM_BUTTONS < MASK_BITS) ? NUM_BUTTONS : MASK_BITS;
  localparam int IW = (NB > 1) ? $clog2(NB) : 1;
  localparam int SW = 2 * STAMP_BITS + CNT_BITS + 2;
  localparam logic [IW-1:0] LAST_BTN = IW'(NB - 1);

  logic                    busy_r, busy_nxt;
  logic                    proc_v_r, proc_v_nxt;
  logic [IW-1:0]           proc_b_r, proc_b_nxt;
  logic [STAMP_BITS-1:0]   now_r, now_nxt;
  logic [MASK_BITS-1:0]    pins_r, pins_nxt;
  logic [NB-1:0]           valid_r, valid_nxt;
  logic [MASK_BITS-1:0]    enable_r, enable_nxt;
  logic [MASK_BITS-1:0]    active_r, active_nxt;
  logic [THR_BITS-1:0]     min_r, min_nxt;
  logic [THR_BITS-1:0]     long_r, long_nxt;
  logic [THR_BITS-1:0]     multi_r, multi_nxt;
  logic                    held_v_r, held_v_nxt;
  bcc_event_t              held_r, held_nxt;
  logic [IDX_OUT_BITS-1:0] held_idx_r, held_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_OUT_BITS-1:0] out_idx_r, out_idx_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [CNT_BITS-1:0]     out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    out_free;
  logic                    step_ok;
  logic                    ram_re;
  logic [IW-1:0]           ram_raddr;
  logic                    ram_we;
  logic [SW-1:0]           ram_rdata;
  logic [SW-1:0]           st_in;
  logic [SW-1:0]           st_out;
  bcc_event_t              ev;
  logic [MASK_BITS-1:0]    newly;

  assign accept    = in_valid & ~busy_r;
  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign step_ok   = ~(ev.valid & held_v_r & ~out_free);
  assign ram_we    = proc_v_r & step_ok;
  assign ram_re    = accept | (proc_v_r & step_ok & (proc_b_r != LAST_BTN));
  assign ram_raddr = accept ? '0 : IW'(proc_b_r + 1'b1);
  assign st_in     = valid_r[proc_b_r] ? ram_rdata : '0;

  bcc_ram #(
    .WIDTH (SW),
    .DEPTH (NB)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (proc_b_r),
    .wdata (st_out),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bcc_update #(
    .STAMP_BITS (STAMP_BITS)
  ) u_update (
    .enable       (proc_v_r & enable_r[proc_b_r]),
    .active_level (active_r[proc_b_r]),
    .pin          (pins_r[proc_b_r]),
    .now          (now_r),
    .min_ms       (min_r),
    .long_ms      (long_r),
    .multi_ms     (multi_r),
    .st_in        (st_in),
    .st_out       (st_out),
    .ev           (ev)
  );

  always_comb begin
    busy_nxt      = busy_r;
    proc_v_nxt    = proc_v_r;
    proc_b_nxt    = proc_b_r;
    now_nxt       = now_r;
    pins_nxt      = pins_r;
    valid_nxt     = valid_r;
    enable_nxt    = enable_r;
    active_nxt    = active_r;
    min_nxt       = min_r;
    long_nxt      = long_r;
    multi_nxt     = multi_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    held_idx_nxt  = held_idx_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_idx_nxt   = out_idx_r;
    out_kind_nxt  = out_kind_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    newly         = cfg_data[MASK_BITS-1:0] & ~enable_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE_MASK: begin
          enable_nxt = cfg_data[MASK_BITS-1:0];
          for (int b = 0; b < NB; b++) begin
            if (newly[b]) begin
              valid_nxt[b] = 1'b0;
            end
          end
        end
        REG_ACTIVE_LEVEL: active_nxt = cfg_data[MASK_BITS-1:0];
        REG_MIN_CLICK:    min_nxt = cfg_data;
        REG_LONG_CLICK:   long_nxt = cfg_data;
        REG_MULTI_CLICK:  multi_nxt = cfg_data;
        default: ;
      endcase
    end

    if (accept) begin
      busy_nxt   = 1'b1;
      proc_v_nxt = 1'b1;
      proc_b_nxt = '0;
      now_nxt    = now_r + 1'b1;
      pins_nxt   = in_pin_levels;
    end

    if (proc_v_r && step_ok) begin
      valid_nxt[proc_b_r] = 1'b1;
      if (ev.valid) begin
        if (held_v_r) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = held_idx_r;
          out_kind_nxt  = held_r.kind;
          out_cnt_nxt   = held_r.count;
          out_last_nxt  = 1'b0;
        end
        held_v_nxt   = 1'b1;
        held_nxt     = ev;
        held_idx_nxt = IDX_OUT_BITS'(proc_b_r);
      end
      if (proc_b_r == LAST_BTN) begin
        proc_v_nxt = 1'b0;
      end else begin
        proc_b_nxt = IW'(proc_b_r + 1'b1);
      end
    end

    // final event of the item goes out with last set; with no event held, busy simply drops
    if (busy_r && !proc_v_r) begin
      if (!held_v_r) begin
        busy_nxt = 1'b0;
      end else if (out_free) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = held_idx_r;
        out_kind_nxt  = held_r.kind;
        out_cnt_nxt   = held_r.count;
        out_last_nxt  = 1'b1;
        held_v_nxt    = 1'b0;
        busy_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      proc_v_r    <= 1'b0;
      proc_b_r    <= '0;
      now_r       <= '0;
      valid_r     <= '0;
      enable_r    <= ENABLE_RST;
      active_r    <= ACTIVE_RST;
      min_r       <= MIN_CLICK_RST;
      long_r      <= LONG_CLICK_RST;
      multi_r     <= MULTI_CLICK_RST;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      proc_v_r    <= proc_v_nxt;
      proc_b_r    <= proc_b_nxt;
      now_r       <= now_nxt;
      valid_r     <= valid_nxt;
      enable_r    <= enable_nxt;
      active_r    <= active_nxt;
      min_r       <= min_nxt;
      long_r      <= long_nxt;
      multi_r     <= multi_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pins_r     <= pins_nxt;
    held_r     <= held_nxt;
    held_idx_r <= held_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_button_index = out_idx_r;
  assign out_event_kind   = out_kind_r;
  assign out_click_count  = out_cnt_r;
  assign out_last_event   = out_last_r;

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !proc_v_r && !held_v_r)
    else $error("item taken while previous item still in flight");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !proc_v_r && !held_v_r |=> !busy_r)
    else $error("block stays busy after last button without pending event");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    proc_v_r && step_ok && (proc_b_r != LAST_BTN) |=> proc_v_r
      && (proc_b_r == IW'($past(proc_b_r) + 1'b1)))
    else $error("button walk skipped or repeated a position");

  a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r && proc_v_r && ev.valid && !out_free |=> held_v_r && $stable(held_r))
    else $error("held event lost while output stalled");

endmodule
